/* sv/sqd_pkg.sv */
// Shared constants, types and state codes for the shortest queue dispatcher.
// Used by sqd_job_store and shortest_queue_dispatcher; depends on nothing.
`timescale 1ns / 1ps

package sqd_pkg;

    localparam int NUM_QUEUES  = 3;
    localparam int QUEUE_DEPTH = 16;

    localparam int QIDX_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HEAD_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int SUM_W     = $clog2(MEM_DEPTH + 1);
    localparam int RES_MAX   = NUM_QUEUES + 1;
    localparam int RES_IDX_W = $clog2(RES_MAX);
    localparam int RES_CNT_W = $clog2(RES_MAX + 1);

    typedef enum logic [1:0] {
        EV_IDLE   = 2'd0,
        EV_ARRIVE = 2'd1,
        EV_DEPART = 2'd2,
        EV_DROP   = 2'd3
    } event_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_PLACE,
        ST_ARRIVE,
        ST_DEPRD,
        ST_DEPCHK,
        ST_SUM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [15:0] job_num;
        logic [31:0] exit_tick;
    } job_t;

    typedef struct packed {
        event_kind_t kind;
        logic [15:0] vnum;
        logic [2:0]  qidx;
        logic [7:0]  svc;
        logic [31:0] exit_time;
    } result_t;

endpackage

/* sv/sqd_job_store.sv */
// Job store: one entry per queue slot holding job number and exit tick.
// Depends on sqd_pkg for depth, address width and the entry type.
`timescale 1ns / 1ps

module sqd_job_store (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [sqd_pkg::ADDR_W-1:0] wr_addr,
    input  sqd_pkg::job_t              wr_data,
    input  logic [sqd_pkg::ADDR_W-1:0] rd_addr,
    output sqd_pkg::job_t              rd_data
);

    sqd_pkg::job_t mem [sqd_pkg::MEM_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/shortest_queue_dispatcher.sv */
// Join-shortest-queue dispatcher: top level with sequencer and queue state.
// Depends on sqd_pkg and sqd_job_store.
`timescale 1ns / 1ps

// Usage
//   One input beat on s_ (valid/ready) is one clock tick of the simulated
//   system and carries the service time of a job that may arrive on it.
//   Every arrival_period ticks a job arrives, joins the shortest queue
//   (lowest index on a tie) or is reported dropped when all are full.
//   Then each queue whose head is due leaves, in queue order.
//   Each tick yields 1 to NUM_QUEUES+1 result beats on m_, the last one
//   flagged by m_last; all beats of a tick carry the same m_length_sum.
//   Work: a tick walks the queues one per cycle through the single read
//   port of the job store; result beats then leave one per cycle while
//   m_ready is high. s_ready is high only between ticks.
//   A stalled receiver holds the current result beat; no new tick is
//   taken until the last beat of the tick is accepted.
//   Reset (aresetn low, synchronous) empties all queues, clears the tick,
//   phase, job number and length total, and sets arrival_period to 2.
//   cfg_wr_en writes arrival_period; write it only between ticks.

module shortest_queue_dispatcher (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_service_time,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_kind,
    output logic [31:0] m_tick,
    output logic [15:0] m_vehicle_number,
    output logic [2:0]  m_queue_index,
    output logic [7:0]  m_job_service,
    output logic [31:0] m_exit_time,
    output logic [31:0] m_length_sum,
    output logic        m_last
);

    // Slot address of a queue entry in the shared job store.
    function automatic logic [sqd_pkg::ADDR_W-1:0] job_addr(
        input logic [sqd_pkg::QIDX_W-1:0] q,
        input logic [sqd_pkg::HEAD_W-1:0] slot
    );
        job_addr = sqd_pkg::ADDR_W'(q) * sqd_pkg::ADDR_W'(sqd_pkg::QUEUE_DEPTH)
                 + sqd_pkg::ADDR_W'(slot);
    endfunction

    // Fold head plus offset back into the ring; the value stays below 2x depth.
    function automatic logic [sqd_pkg::HEAD_W-1:0] wrap_slot(
        input logic [sqd_pkg::CNT_W:0] v
    );
        logic [sqd_pkg::CNT_W:0] w;
        w = v;
        if (w >= (sqd_pkg::CNT_W + 1)'(sqd_pkg::QUEUE_DEPTH)) begin
            w = w - (sqd_pkg::CNT_W + 1)'(sqd_pkg::QUEUE_DEPTH);
        end
        wrap_slot = w[sqd_pkg::HEAD_W-1:0];
    endfunction

    // Sequencer and tick state
    sqd_pkg::state_t                state_reg, state_next;
    logic [31:0]                    tick_reg, tick_next;
    logic [7:0]                     phase_reg, phase_next;
    logic [15:0]                    vcount_reg, vcount_next;
    logic [7:0]                     period_reg;
    logic [7:0]                     svc_reg, svc_next;
    logic [sqd_pkg::QIDX_W-1:0]     q_reg, q_next;
    logic [sqd_pkg::QIDX_W-1:0]     best_reg, best_next;
    logic                           tail_vld_reg, tail_vld_next;
    logic [31:0]                    total_reg, total_next;

    // Per-queue ring pointers
    logic [sqd_pkg::HEAD_W-1:0]     head_reg  [sqd_pkg::NUM_QUEUES];
    logic [sqd_pkg::HEAD_W-1:0]     head_next [sqd_pkg::NUM_QUEUES];
    logic [sqd_pkg::CNT_W-1:0]      cnt_reg   [sqd_pkg::NUM_QUEUES];
    logic [sqd_pkg::CNT_W-1:0]      cnt_next  [sqd_pkg::NUM_QUEUES];

    // Result buffer for one tick
    sqd_pkg::result_t               res_buf_reg [sqd_pkg::RES_MAX];
    logic [sqd_pkg::RES_CNT_W-1:0]  res_cnt_reg, res_cnt_next;
    logic [sqd_pkg::RES_IDX_W-1:0]  emit_idx_reg, emit_idx_next;
    logic                           res_push;
    sqd_pkg::result_t               res_entry;

    // Job store port
    logic                           mem_we;
    logic [sqd_pkg::ADDR_W-1:0]     mem_waddr;
    sqd_pkg::job_t                  mem_wdata;
    logic [sqd_pkg::ADDR_W-1:0]     mem_raddr;
    sqd_pkg::job_t                  mem_rdata;

    // Shared datapath temporaries
    logic [7:0]                     phase_inc;
    logic [31:0]                    start_tick;
    logic [31:0]                    exit_tick;
    logic [sqd_pkg::SUM_W-1:0]      len_sum;
    logic [32:0]                    total_add;
    logic [sqd_pkg::QIDX_W-1:0]     q_inc;
    sqd_pkg::result_t               res_out;

    sqd_job_store u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sqd_pkg::ST_IDLE;
            tick_reg     <= '0;
            phase_reg    <= '0;
            vcount_reg   <= '0;
            period_reg   <= 8'd2;
            q_reg        <= '0;
            best_reg     <= '0;
            tail_vld_reg <= 1'b0;
            total_reg    <= '0;
            res_cnt_reg  <= '0;
            emit_idx_reg <= '0;
            for (int i = 0; i < sqd_pkg::NUM_QUEUES; i++) begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end else begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            phase_reg    <= phase_next;
            vcount_reg   <= vcount_next;
            q_reg        <= q_next;
            best_reg     <= best_next;
            tail_vld_reg <= tail_vld_next;
            total_reg    <= total_next;
            res_cnt_reg  <= res_cnt_next;
            emit_idx_reg <= emit_idx_next;
            head_reg     <= head_next;
            cnt_reg      <= cnt_next;
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        svc_reg <= svc_next;
        if (res_push) begin
            res_buf_reg[res_cnt_reg[sqd_pkg::RES_IDX_W-1:0]] <= res_entry;
        end
    end

    always_comb begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        phase_next    = phase_reg;
        vcount_next   = vcount_reg;
        svc_next      = svc_reg;
        q_next        = q_reg;
        best_next     = best_reg;
        tail_vld_next = tail_vld_reg;
        total_next    = total_reg;
        res_cnt_next  = res_cnt_reg;
        emit_idx_next = emit_idx_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;

        res_push      = 1'b0;
        res_entry     = '0;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_raddr     = '0;
        s_ready       = 1'b0;
        m_valid       = 1'b0;

        phase_inc     = phase_reg + 8'd1;
        q_inc         = q_reg + sqd_pkg::QIDX_W'(1);
        start_tick    = tick_reg;
        exit_tick     = '0;
        len_sum       = '0;
        total_add     = '0;

        case (state_reg)
            sqd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    tick_next = tick_reg + 32'd1;
                    svc_next  = s_service_time;
                    best_next = '0;
                    // Period zero acts as one: any phase reaches it.
                    if (phase_inc >= period_reg) begin
                        phase_next  = '0;
                        vcount_next = vcount_reg + 16'd1;
                        if (sqd_pkg::NUM_QUEUES > 1) begin
                            q_next     = sqd_pkg::QIDX_W'(1);
                            state_next = sqd_pkg::ST_FIND;
                        end else begin
                            state_next = sqd_pkg::ST_PLACE;
                        end
                    end else begin
                        phase_next = phase_inc;
                        q_next     = '0;
                        state_next = sqd_pkg::ST_DEPRD;
                    end
                end
            end

            // Walk the queues one per cycle for the shortest; strict less keeps ties low.
            sqd_pkg::ST_FIND: begin
                if (cnt_reg[q_reg] < cnt_reg[best_reg]) begin
                    best_next = q_reg;
                end
                if (q_reg == sqd_pkg::QIDX_W'(sqd_pkg::NUM_QUEUES - 1)) begin
                    state_next = sqd_pkg::ST_PLACE;
                end else begin
                    q_next = q_inc;
                end
            end

            sqd_pkg::ST_PLACE: begin
                if (cnt_reg[best_reg] >= sqd_pkg::CNT_W'(sqd_pkg::QUEUE_DEPTH)) begin
                    res_push  = 1'b1;
                    res_entry = '{kind: sqd_pkg::EV_DROP, vnum: vcount_reg, qidx: 3'd0,
                                  svc: svc_reg, exit_time: 32'd0};
                    q_next     = '0;
                    state_next = sqd_pkg::ST_DEPRD;
                end else begin
                    tail_vld_next = (cnt_reg[best_reg] != '0);
                    if (cnt_reg[best_reg] != '0) begin
                        // Fetch the tail's exit tick.
                        mem_raddr = job_addr(best_reg,
                            wrap_slot((sqd_pkg::CNT_W + 1)'(head_reg[best_reg])
                                      + (sqd_pkg::CNT_W + 1)'(cnt_reg[best_reg])
                                      - (sqd_pkg::CNT_W + 1)'(1)));
                    end
                    state_next = sqd_pkg::ST_ARRIVE;
                end
            end

            sqd_pkg::ST_ARRIVE: begin
                if (tail_vld_reg && (mem_rdata.exit_tick > tick_reg)) begin
                    start_tick = mem_rdata.exit_tick;
                end
                exit_tick = start_tick + 32'(svc_reg);
                mem_we    = 1'b1;
                mem_waddr = job_addr(best_reg,
                    wrap_slot((sqd_pkg::CNT_W + 1)'(head_reg[best_reg])
                              + (sqd_pkg::CNT_W + 1)'(cnt_reg[best_reg])));
                mem_wdata = '{job_num: vcount_reg, exit_tick: exit_tick};
                cnt_next[best_reg] = cnt_reg[best_reg] + sqd_pkg::CNT_W'(1);
                res_push  = 1'b1;
                res_entry = '{kind: sqd_pkg::EV_ARRIVE, vnum: vcount_reg,
                              qidx: 3'(best_reg), svc: svc_reg, exit_time: exit_tick};
                q_next     = '0;
                state_next = sqd_pkg::ST_DEPRD;
            end

            sqd_pkg::ST_DEPRD: begin
                mem_raddr  = job_addr(q_reg, head_reg[q_reg]);
                state_next = sqd_pkg::ST_DEPCHK;
            end

            // Check one head per cycle; fetch the next queue's head meanwhile.
            sqd_pkg::ST_DEPCHK: begin
                if ((cnt_reg[q_reg] != '0) && (mem_rdata.exit_tick == tick_reg)) begin
                    res_push  = 1'b1;
                    res_entry = '{kind: sqd_pkg::EV_DEPART, vnum: mem_rdata.job_num,
                                  qidx: 3'(q_reg), svc: 8'd0, exit_time: 32'd0};
                    if (head_reg[q_reg] == sqd_pkg::HEAD_W'(sqd_pkg::QUEUE_DEPTH - 1)) begin
                        head_next[q_reg] = '0;
                    end else begin
                        head_next[q_reg] = head_reg[q_reg] + sqd_pkg::HEAD_W'(1);
                    end
                    cnt_next[q_reg] = cnt_reg[q_reg] - sqd_pkg::CNT_W'(1);
                end
                if (q_reg == sqd_pkg::QIDX_W'(sqd_pkg::NUM_QUEUES - 1)) begin
                    state_next = sqd_pkg::ST_SUM;
                end else begin
                    q_next     = q_inc;
                    mem_raddr  = job_addr(q_inc, head_reg[q_inc]);
                end
            end

            sqd_pkg::ST_SUM: begin
                for (int i = 0; i < sqd_pkg::NUM_QUEUES; i++) begin
                    len_sum = len_sum + sqd_pkg::SUM_W'(cnt_reg[i]);
                end
                total_add = {1'b0, total_reg} + 33'(len_sum);
                // Saturate at all ones.
                total_next = total_add[32] ? 32'hFFFF_FFFF : total_add[31:0];
                if (res_cnt_reg == '0) begin
                    res_push  = 1'b1;
                    res_entry = '{kind: sqd_pkg::EV_IDLE, vnum: 16'd0, qidx: 3'd0,
                                  svc: 8'd0, exit_time: 32'd0};
                end
                emit_idx_next = '0;
                state_next    = sqd_pkg::ST_EMIT;
            end

            sqd_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (sqd_pkg::RES_CNT_W'(emit_idx_reg) + sqd_pkg::RES_CNT_W'(1)
                        == res_cnt_reg) begin
                        res_cnt_next = '0;
                        state_next   = sqd_pkg::ST_IDLE;
                    end else begin
                        emit_idx_next = emit_idx_reg + sqd_pkg::RES_IDX_W'(1);
                    end
                end
            end

            default: begin
                state_next = sqd_pkg::ST_IDLE;
            end
        endcase

        if (res_push) begin
            res_cnt_next = res_cnt_reg + sqd_pkg::RES_CNT_W'(1);
        end
    end

    // Present the buffered beat selected by the emit index.
    assign res_out          = res_buf_reg[emit_idx_reg];
    assign m_event_kind     = res_out.kind;
    assign m_tick           = tick_reg;
    assign m_vehicle_number = res_out.vnum;
    assign m_queue_index    = res_out.qidx;
    assign m_job_service    = res_out.svc;
    assign m_exit_time      = res_out.exit_time;
    assign m_length_sum     = total_reg;
    assign m_last           = (sqd_pkg::RES_CNT_W'(emit_idx_reg) + sqd_pkg::RES_CNT_W'(1))
                              == res_cnt_reg;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for shortest_queue_dispatcher: tick beats in, event beats out.
// Depends on sqd_pkg and the shortest_queue_dispatcher RTL; needs nothing else.
`timescale 1ns / 1ps

module tb;

    // Cycles to let pass once the last expected beat has arrived: time for one
    // full arrival tick of work plus slack.
    localparam int SETTLE_CYCLES = 16;
    // Length of the long receiver hold-off, in clock cycles.
    localparam int LONG_HOLD     = 400;
    // Cap on printed mismatch lines so a broken block cannot flood the log.
    localparam int PRINT_CAP     = 40;

    typedef enum int {SVC_ANY, SVC_SHORT, SVC_LONG} svc_style_t;
    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    // One expected event beat.
    typedef struct {
        sqd_pkg::event_kind_t kind;
        logic [31:0] tick;
        logic [15:0] vnum;
        logic [2:0]  qidx;
        logic [7:0]  svc;
        logic [31:0] exit_time;
        logic [31:0] length_sum;
        logic        last;
    } dispatch_event_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value.
    // ------------------------------------------------------------------
    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [7:0]  cfg_wr_data    = 8'd0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_service_time = 8'd0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [1:0]  m_event_kind;
    logic [31:0] m_tick;
    logic [15:0] m_vehicle_number;
    logic [2:0]  m_queue_index;
    logic [7:0]  m_job_service;
    logic [31:0] m_exit_time;
    logic [31:0] m_length_sum;
    logic        m_last;

    always #5 aclk = ~aclk;

    shortest_queue_dispatcher DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_service_time   (s_service_time),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_tick           (m_tick),
        .m_vehicle_number (m_vehicle_number),
        .m_queue_index    (m_queue_index),
        .m_job_service    (m_job_service),
        .m_exit_time      (m_exit_time),
        .m_length_sum     (m_length_sum),
        .m_last           (m_last)
    );

    // ------------------------------------------------------------------
    // Dispatcher predictor state: a private copy of the queues and counters.
    // ------------------------------------------------------------------
    logic [7:0]  period_reg;
    logic [31:0] sim_tick;
    logic [7:0]  arr_phase;
    logic [15:0] job_seq;
    logic [15:0] slot_job  [sqd_pkg::NUM_QUEUES][sqd_pkg::QUEUE_DEPTH];
    logic [31:0] slot_exit [sqd_pkg::NUM_QUEUES][sqd_pkg::QUEUE_DEPTH];
    int          q_head    [sqd_pkg::NUM_QUEUES];
    int          q_len     [sqd_pkg::NUM_QUEUES];
    logic [31:0] len_total;

    dispatch_event_t dispatch_exp_q[$];   // expected event beats, oldest first
    logic [7:0]      svc_pend_q[$];       // tick beats waiting for the driver

    int       mismatch_count = 0;
    int       burst_left     = 0;
    int       gap_left       = 0;
    bit       tx_gaps        = 1'b0;
    rx_mode_t rx_mode        = RX_ALWAYS;
    int       hold_req_cnt   = 0;
    int       hold_ack_cnt   = 0;
    int       hold_left      = 0;
    int       pat_pos        = 0;
    dispatch_event_t want_ev;

    function automatic dispatch_event_t make_event(sqd_pkg::event_kind_t kind,
                                                   logic [15:0] vnum,
                                                   logic [2:0] qidx, logic [7:0] svc,
                                                   logic [31:0] ex);
        dispatch_event_t ev;
        ev.kind       = kind;
        ev.tick       = sim_tick;
        ev.vnum       = vnum;
        ev.qidx       = qidx;
        ev.svc        = svc;
        ev.exit_time  = ex;
        ev.length_sum = '0;
        ev.last       = 1'b0;
        return ev;
    endfunction

    // Advance the predictor by one tick and queue the event beats it yields.
    task automatic dispatch_tick(input logic [7:0] svc);
        dispatch_event_t evs[$];
        dispatch_event_t ev;
        int          best;
        int          q;
        int          tail;
        int          slot;
        int          occupancy;
        logic [31:0] start_t;
        logic [31:0] ex;
        logic [32:0] acc;

        sim_tick  = sim_tick + 32'd1;
        arr_phase = arr_phase + 8'd1;

        // Arrival: phase reaching or passing the period, so a period of zero
        // or one lowered below the phase fires at once.
        if (arr_phase >= period_reg) begin
            arr_phase = '0;
            job_seq   = job_seq + 16'd1;
            best      = 0;
            for (q = 1; q < sqd_pkg::NUM_QUEUES; q++)
                if (q_len[q] < q_len[best])
                    best = q;
            if (q_len[best] >= sqd_pkg::QUEUE_DEPTH) begin
                // Every queue full: report and discard the job.
                evs.push_back(make_event(sqd_pkg::EV_DROP, job_seq, 3'd0, svc, 32'd0));
            end else begin
                start_t = sim_tick;
                if (q_len[best] > 0) begin
                    tail = (q_head[best] + q_len[best] - 1) % sqd_pkg::QUEUE_DEPTH;
                    if (slot_exit[best][tail] > start_t)
                        start_t = slot_exit[best][tail];
                end
                ex   = start_t + {24'd0, svc};
                slot = (q_head[best] + q_len[best]) % sqd_pkg::QUEUE_DEPTH;
                slot_job[best][slot]  = job_seq;
                slot_exit[best][slot] = ex;
                q_len[best]++;
                evs.push_back(make_event(sqd_pkg::EV_ARRIVE, job_seq, best[2:0], svc, ex));
            end
        end

        // Departures in queue order, at most one per queue; a zero service
        // time lets a job that just arrived leave in the same tick.
        for (q = 0; q < sqd_pkg::NUM_QUEUES; q++) begin
            if (q_len[q] > 0 && slot_exit[q][q_head[q]] == sim_tick) begin
                evs.push_back(make_event(sqd_pkg::EV_DEPART, slot_job[q][q_head[q]],
                                         q[2:0], 8'd0, 32'd0));
                q_head[q] = (q_head[q] + 1) % sqd_pkg::QUEUE_DEPTH;
                q_len[q]--;
            end
        end

        if (evs.size() == 0)
            evs.push_back(make_event(sqd_pkg::EV_IDLE, 16'd0, 3'd0, 8'd0, 32'd0));

        // Saturating running total of queue lengths.
        occupancy = 0;
        for (q = 0; q < sqd_pkg::NUM_QUEUES; q++)
            occupancy += q_len[q];
        acc = {1'b0, len_total} + 33'(occupancy);
        len_total = acc[32] ? 32'hFFFF_FFFF : acc[31:0];

        foreach (evs[i]) begin
            ev            = evs[i];
            ev.length_sum = len_total;
            ev.last       = (i == evs.size() - 1);
            dispatch_exp_q.push_back(ev);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: feed tick beats from svc_pend_q in bursts, with random gaps when tx_gaps is set.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready)
                dispatch_tick(s_service_time);
            // Hold valid and payload until the beat is taken.
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (svc_pend_q.size() > 0) begin
                    s_valid        <= 1'b1;
                    s_service_time <= svc_pend_q.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = tx_gaps ? $urandom_range(0, 15) : 0;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on the selected pattern; a hold-off request starts a
    // long stretch of m_ready low, counted here.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
            pat_pos   = 0;
        end else begin
            if (hold_req_cnt != hold_ack_cnt) begin
                hold_ack_cnt = hold_req_cnt;
                hold_left    = LONG_HOLD;
            end
            pat_pos = (pat_pos + 1) % 7;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                    default:   m_ready <= (pat_pos >= 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted event beat with the oldest expectation.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (mismatch_count < PRINT_CAP)
                $display("%0t: %s mismatch at tick %0d: expected %0d, actual %0d",
                         $time, name, want_ev.tick, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (dispatch_exp_q.size() == 0) begin
                if (mismatch_count < PRINT_CAP)
                    $display("%0t: unexpected event beat: expected none, %s %0d tick %0d",
                             $time, "actual kind", m_event_kind, m_tick);
                mismatch_count++;
            end else begin
                want_ev = dispatch_exp_q.pop_front();
                check_field("event_kind",     want_ev.kind,       m_event_kind);
                check_field("tick",           want_ev.tick,       m_tick);
                check_field("vehicle_number", want_ev.vnum,       m_vehicle_number);
                check_field("queue_index",    want_ev.qidx,       m_queue_index);
                check_field("job_service",    want_ev.svc,        m_job_service);
                check_field("exit_time",      want_ev.exit_time,  m_exit_time);
                check_field("length_sum",     want_ev.length_sum, m_length_sum);
                check_field("last",           want_ev.last,       m_last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing.
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_service(svc_style_t style);
        case (style)
            SVC_SHORT: return ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 20));
            SVC_LONG:  return 8'($urandom_range(150, 255));
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Wait until every beat is sent and every expected result is back, then settle.
    task automatic drain();
        while (svc_pend_q.size() != 0 || s_valid || dispatch_exp_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write arrival_period; only called with the block idle.
    task automatic program_period(input logic [7:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        period_reg  = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Queue a batch of random tick beats and wait for all their results.
    task automatic run_ticks(input int count, input svc_style_t style);
        @(negedge aclk);
        repeat (count) svc_pend_q.push_back(pick_service(style));
        drain();
    endtask

    task automatic run_list(input logic [7:0] vals[$]);
        @(negedge aclk);
        foreach (vals[i]) svc_pend_q.push_back(vals[i]);
        drain();
    endtask

    initial begin
        logic [7:0] rand_periods[$];

        period_reg = 8'd2;
        sim_tick   = '0;
        arr_phase  = '0;
        job_seq    = '0;
        len_total  = '0;
        for (int q = 0; q < sqd_pkg::NUM_QUEUES; q++) begin
            q_head[q] = 0;
            q_len[q]  = 0;
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset period, service extremes and zero service that
        // leaves in the arrival tick.
        run_list('{8'd0, 8'd255, 8'd1, 8'd0, 8'd254, 8'hAA, 8'h55, 8'd128,
                   8'd0, 8'd1, 8'd2, 8'd255});

        // Directed: period zero behaves as one; arrivals every tick.
        rx_mode = RX_PATTERN;
        program_period(8'd0);
        run_list('{8'd0, 8'd0, 8'd1, 8'd0, 8'd255, 8'd3, 8'd0, 8'd0});

        // Longest period, then lower it below the phase: fire immediately.
        tx_gaps = 1'b1;
        rx_mode = RX_RANDOM;
        program_period(8'd255);
        run_ticks(60, SVC_SHORT);
        program_period(8'd40);
        run_ticks(30, SVC_ANY);

        // Random phases at short periods with mixed idling; hold the
        // receiver off for a long stretch in one of them so the block
        // backs up and stalls its input.
        rand_periods = '{8'd1, 8'($urandom_range(2, 6)), 8'd3, 8'($urandom_range(1, 8)),
                         8'd0};
        foreach (rand_periods[i]) begin
            tx_gaps = (i % 2 == 0);
            rx_mode = rx_mode_t'(i % 3);
            program_period(rand_periods[i]);
            @(negedge aclk);
            if (i == 1)
                hold_req_cnt++;
            run_ticks(24, ($urandom_range(0, 2) == 0) ? SVC_ANY : SVC_SHORT);
        end

        // Fill every queue with long jobs at one arrival per tick until
        // arrivals are dropped, then keep going with mixed service times.
        tx_gaps = 1'b0;
        rx_mode = RX_RANDOM;
        program_period(8'd1);
        @(negedge aclk);
        hold_req_cnt++;
        run_ticks(55, SVC_LONG);
        tx_gaps = 1'b1;
        run_ticks(25, SVC_ANY);

        drain();
        if (mismatch_count == 0 && dispatch_exp_q.size() == 0)
            $display("shortest_queue_dispatcher regression: pass");
        else
            $display("shortest_queue_dispatcher regression: fail");
        $finish;
    end

    // Drop the run if it hangs.
    initial begin
        #3_000_000;
        $display("shortest_queue_dispatcher regression: fail");
        $finish;
    end

endmodule
